@@ rtl/pfa_pkg.sv @@
// Shared constants, codes, state and control types of the page-frame allocator.
package pfa_pkg;

   localparam int NUM_PAGES   = 1024;
   localparam int PAGE_SHIFT  = 12;
   localparam int ADDR_BITS   = 48;

   localparam int FIELD_ADDR_W = 48;
   localparam int CSR_DATA_W   = 48;
   localparam int CSR_IDX_W    = 2;
   localparam int COUNT_W      = 11;

   localparam int ROW_BITS    = 64;
   localparam int NUM_ROWS    = NUM_PAGES / ROW_BITS;
   localparam int ROW_IDX_W   = $clog2(NUM_ROWS);
   localparam int BIT_IDX_W   = $clog2(ROW_BITS);
   localparam int PAGE_IDX_W  = ROW_IDX_W + BIT_IDX_W;
   localparam int FIDX_W      = FIELD_ADDR_W - PAGE_SHIFT;

   typedef enum logic [0:0] {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NO_PAGE = 2'd1,
      STATUS_RANGE   = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MEM_BASE       = 2'd0,
      REG_PAGE_COUNT     = 2'd1,
      REG_RESERVED_PAGES = 2'd2
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FREE_CALC,
      ST_FREE_READ,
      ST_FREE_WRITE,
      ST_RESPOND
   } pfa_state_type;

   typedef struct packed {
      logic capture;
      logic start_alloc;
      logic scan_step;
      logic alloc_commit;
      logic alloc_fail;
      logic free_calc;
      logic free_commit;
      logic free_fail;
      logic out_load;
   } pfa_ctl_type;

   typedef struct packed {
      logic hit;
      logic exhausted;
      logic free_ok;
      logic out_free;
   } pfa_sts_type;

endpackage

@@ rtl/pfa_if.sv @@
// Request and response channel interfaces of the page-frame allocator.
interface pfa_req_if;
   import pfa_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    cmd;
   logic [FIELD_ADDR_W-1:0] free_addr;

   modport source (output valid, output cmd, output free_addr, input ready);
   modport sink   (input valid, input cmd, input free_addr, output ready);
endinterface

interface pfa_rsp_if;
   import pfa_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [FIELD_ADDR_W-1:0] page_addr;
   logic [1:0]              status;

   modport source (output valid, output page_addr, output status, input ready);
   modport sink   (input valid, input page_addr, input status, output ready);
endinterface

@@ rtl/pfa_controller.sv @@
// Sequencing state machine of the page-frame allocator.
module pfa_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_cmd,
   output logic                 req_ready,
   input  pfa_pkg::pfa_sts_type sts,
   output pfa_pkg::pfa_ctl_type ctl
);
   import pfa_pkg::*;

   pfa_state_type state_ff;
   pfa_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_cmd == CMD_FREE) ? ST_FREE_CALC : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.hit || sts.exhausted) begin
               state_in = ST_RESPOND;
            end
         end
         ST_FREE_CALC: state_in = ST_FREE_READ;
         ST_FREE_READ: state_in = sts.free_ok ? ST_FREE_WRITE : ST_RESPOND;
         ST_FREE_WRITE: state_in = ST_RESPOND;
         ST_RESPOND: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready       = 1'b1;
            ctl.capture     = req_valid;
            ctl.start_alloc = req_valid && (req_cmd == CMD_ALLOC);
         end
         ST_SCAN: begin
            ctl.scan_step    = !(sts.hit || sts.exhausted);
            ctl.alloc_commit = sts.hit;
            ctl.alloc_fail   = sts.exhausted;
         end
         ST_FREE_CALC: ctl.free_calc = 1'b1;
         ST_FREE_READ: ctl.free_fail = !sts.free_ok;
         ST_FREE_WRITE: ctl.free_commit = 1'b1;
         ST_RESPOND: ctl.out_load = sts.out_free;
         default: ctl = '0;
      endcase
   end

endmodule

@@ rtl/pfa_datapath.sv @@
// Flag memory, row scanner, address arithmetic and output register of the allocator.
module pfa_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wen,
   input  logic [pfa_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [pfa_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic [pfa_pkg::FIELD_ADDR_W-1:0]      req_free_addr,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [pfa_pkg::FIELD_ADDR_W-1:0]      rsp_page_addr,
   output pfa_pkg::status_type                   rsp_status,
   input  pfa_pkg::pfa_ctl_type                  ctl,
   output pfa_pkg::pfa_sts_type                  sts
);
   import pfa_pkg::*;

   logic [FIELD_ADDR_W-1:0] mem_base_ff;
   logic [COUNT_W-1:0]      frame_total_ff;
   logic [COUNT_W-1:0]      reserved_ff;

   logic [ROW_BITS-1:0]     row_mem [NUM_ROWS];
   logic [NUM_ROWS-1:0]     row_valid_ff;
   logic [ROW_BITS-1:0]     rd_row_ff;
   logic                    rd_valid_ff;

   logic [ROW_IDX_W-1:0]    addr_ff, addr_in;
   logic [ROW_IDX_W-1:0]    chk_row_ff;
   logic                    chk_live_ff;
   logic [BIT_IDX_W-1:0]    bit_ff, bit_in;
   logic                    free_ok_ff, free_ok_in;
   logic [FIELD_ADDR_W-1:0] faddr_ff, faddr_in;

   logic [FIELD_ADDR_W-1:0] res_addr_ff, res_addr_in;
   status_type              res_status_ff, res_status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [FIELD_ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   status_type              rsp_status_ff, rsp_status_in;

   logic [ROW_BITS-1:0]     row_eff;
   logic [ROW_BITS-1:0]     boot_row;
   logic [ROW_BITS-1:0]     live_row;
   logic [ROW_BITS-1:0]     free_vec;
   logic [ROW_BITS-1:0]     low_onehot;
   logic [BIT_IDX_W-1:0]    hit_bit;
   logic [COUNT_W-1:0]      next_base;
   logic                    last_row;
   logic [PAGE_IDX_W-1:0]   alloc_idx;
   logic [ADDR_BITS-1:0]    alloc_sum;

   logic                    below_base;
   logic [FIELD_ADDR_W-1:0] fdiff;
   logic [FIDX_W-1:0]       fidx;
   logic [COUNT_W-1:0]      limit;
   logic                    in_range;

   logic                    wr_en;
   logic [ROW_BITS-1:0]     wr_row;

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_base_ff    <= '0;
         frame_total_ff <= COUNT_W'(NUM_PAGES);
         reserved_ff    <= '0;
      end else if (csr_wen) begin
         case (reg_index_type'(csr_index))
            REG_MEM_BASE:       mem_base_ff    <= csr_wdata[FIELD_ADDR_W-1:0];
            REG_PAGE_COUNT:     frame_total_ff <= csr_wdata[COUNT_W-1:0];
            REG_RESERVED_PAGES: reserved_ff    <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[chk_row_ff] <= wr_row;
      end
      rd_row_ff <= row_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            row_valid_ff[chk_row_ff] <= 1'b1;
         end
         rd_valid_ff <= row_valid_ff[addr_ff];
      end
   end

   always_comb begin
      logic [PAGE_IDX_W-1:0] idx;
      row_eff = rd_valid_ff ? rd_row_ff : '0;
      for (int j = 0; j < ROW_BITS; j++) begin
         idx         = {chk_row_ff, BIT_IDX_W'(j)};
         boot_row[j] = {{(COUNT_W-PAGE_IDX_W){1'b0}}, idx} < reserved_ff;
         live_row[j] = {{(COUNT_W-PAGE_IDX_W){1'b0}}, idx} < frame_total_ff;
      end
      free_vec   = live_row & ~(boot_row ^ row_eff);
      low_onehot = free_vec & (~free_vec + 1'b1);
      hit_bit    = '0;
      for (int j = 0; j < ROW_BITS; j++) begin
         if (low_onehot[j]) begin
            hit_bit = hit_bit | BIT_IDX_W'(j);
         end
      end
      last_row  = (chk_row_ff == ROW_IDX_W'(NUM_ROWS - 1));
      next_base = COUNT_W'({({1'b0, chk_row_ff} + 1'b1), {BIT_IDX_W{1'b0}}});
      alloc_idx = {chk_row_ff, hit_bit};
      alloc_sum = ADDR_BITS'(mem_base_ff) + (ADDR_BITS'(alloc_idx) << PAGE_SHIFT);
   end

   assign sts.hit       = chk_live_ff && (|free_vec);
   assign sts.exhausted = chk_live_ff && !(|free_vec) &&
                          (last_row || (next_base >= frame_total_ff));
   assign sts.free_ok   = free_ok_ff;
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      below_base = faddr_ff < mem_base_ff;
      fdiff      = faddr_ff - mem_base_ff;
      fidx       = fdiff[FIELD_ADDR_W-1:PAGE_SHIFT];
      limit      = (frame_total_ff > COUNT_W'(NUM_PAGES)) ? COUNT_W'(NUM_PAGES)
                                                           : frame_total_ff;
      in_range   = !below_base && (fidx < {{(FIDX_W-COUNT_W){1'b0}}, limit});
   end

   always_comb begin
      wr_en  = ctl.alloc_commit || ctl.free_commit;
      wr_row = row_eff;
      if (ctl.alloc_commit) begin
         wr_row = row_eff ^ low_onehot;
      end else begin
         wr_row[bit_ff] = boot_row[bit_ff];
      end
   end

   always_comb begin
      addr_in = addr_ff;
      bit_in  = bit_ff;
      if (ctl.start_alloc) begin
         addr_in = '0;
      end else if (ctl.scan_step) begin
         addr_in = addr_ff + 1'b1;
      end else if (ctl.free_calc) begin
         addr_in = fidx[PAGE_IDX_W-1:BIT_IDX_W];
         bit_in  = fidx[BIT_IDX_W-1:0];
      end
      free_ok_in = ctl.free_calc ? in_range : free_ok_ff;
      faddr_in   = ctl.capture ? req_free_addr : faddr_ff;
   end

   always_comb begin
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      if (ctl.alloc_commit) begin
         res_addr_in   = FIELD_ADDR_W'(alloc_sum);
         res_status_in = STATUS_OK;
      end else if (ctl.alloc_fail) begin
         res_addr_in   = '0;
         res_status_in = STATUS_NO_PAGE;
      end else if (ctl.free_fail) begin
         res_addr_in   = '0;
         res_status_in = STATUS_RANGE;
      end else if (ctl.free_commit) begin
         res_addr_in   = '0;
         res_status_in = STATUS_OK;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      if (ctl.out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_addr_in   = res_addr_ff;
         rsp_status_in = res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chk_live_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         chk_live_ff  <= ctl.scan_step;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      chk_row_ff    <= addr_ff;
      bit_ff        <= bit_in;
      free_ok_ff    <= free_ok_in;
      faddr_ff      <= faddr_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_page_addr = rsp_addr_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

@@ rtl/page_frame_allocator_unit.sv @@
// Top level of the first-fit page-frame allocator.
// The req channel carries one transaction per request: cmd selects allocate or
// free, and free_addr names the page to release. The rsp channel returns one
// transaction per request with the page address and a status code.
// The user must write the base address, managed page total and reserved page
// registers through the csr port while the block is idle; it is not enforced.
// An allocate scans the flag memory one 64-page row per cycle through its single
// read port until it finds a free page or runs out of managed rows.
// A free steps through range check, row read, row write and response.
// A free outside the managed range skips the row write.
// One request is worked on at a time; the next is accepted in the cycle after
// the current result has moved into the output register, even if the receiver
// has not yet taken it.
// A stalled receiver holds the response steady, and the block
// stops before loading another result until that slot frees.
// Reset restores the bootstrap state at once: all row flags read as clear,
// and the registers return to base 0, 1024 pages and no reserved pages.
module page_frame_allocator_unit (
   input  logic                           clock,
   input  logic                           reset,
   pfa_req_if.sink                        req,
   pfa_rsp_if.source                      rsp,
   input  logic                           csr_wen,
   input  logic [pfa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pfa_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import pfa_pkg::*;

   pfa_ctl_type ctl;
   pfa_sts_type sts;
   status_type  rsp_status;

   pfa_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_cmd   (req.cmd),
      .req_ready (req.ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   pfa_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_wen       (csr_wen),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_free_addr (req.free_addr),
      .rsp_valid     (rsp.valid),
      .rsp_ready     (rsp.ready),
      .rsp_page_addr (rsp.page_addr),
      .rsp_status    (rsp_status),
      .ctl           (ctl),
      .sts           (sts)
   );

   assign rsp.status = rsp_status;

   assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("Request accepted while a transaction is still in progress.");

   assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.alloc_commit, ctl.alloc_fail, ctl.free_commit, ctl.free_fail}))
      else $error("More than one result was produced in a single cycle.");

   assert property (@(posedge clock) disable iff (reset)
      ctl.out_load |=> rsp.valid)
      else $error("Loaded result did not appear on the response channel.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (rsp.status != STATUS_OK)) |-> (rsp.page_addr == '0))
      else $error("Error response carries a nonzero page address.");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the page-frame allocator with a first-fit predictor.
module tb_top;
   import pfa_pkg::*;

   localparam int IDLE_PERCENT  = 14;
   localparam int STALL_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 40;
   localparam int OFFSET_MAX    = (1 << PAGE_SHIFT) - 1;

   typedef struct packed {
      logic [FIELD_ADDR_W-1:0] page_addr;
      status_type              status;
   } frame_result_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_wen;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   pfa_req_if req_if();
   pfa_rsp_if rsp_if();

   page_frame_allocator_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic [FIELD_ADDR_W-1:0] base_addr;
   logic [COUNT_W-1:0]      page_limit;
   logic [COUNT_W-1:0]      reserved_count;
   bit                      page_flipped [NUM_PAGES];
   frame_result_type        pending_frames [$];
   int                      mismatches = 0;
   int                      quiet_cycles = 0;
   bit                      steady_traffic = 1'b0;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic int managed_count();
      return (page_limit < NUM_PAGES) ? int'(page_limit) : NUM_PAGES;
   endfunction

   function automatic bit page_is_used(int idx);
      return (idx < int'(reserved_count)) ^ page_flipped[idx];
   endfunction

   function automatic void mark_page(int idx, bit used);
      page_flipped[idx] = used ^ (idx < int'(reserved_count));
   endfunction

   function automatic frame_result_type allocate_or_free(cmd_type op,
                                                         logic [FIELD_ADDR_W-1:0] addr);
      frame_result_type        res;
      logic [FIELD_ADDR_W-1:0] offset;
      longint                  page_index;
      int                      i;
      res.page_addr = '0;
      res.status    = STATUS_OK;
      if (op == CMD_ALLOC) begin
         res.status = STATUS_NO_PAGE;
         for (i = 0; i < managed_count() && res.status == STATUS_NO_PAGE; i++) begin
            if (!page_is_used(i)) begin
               mark_page(i, 1'b1);
               res.page_addr = base_addr + (FIELD_ADDR_W'(i) << PAGE_SHIFT);
               res.status    = STATUS_OK;
            end
         end
      end else if (addr < base_addr) begin
         res.status = STATUS_RANGE;
      end else begin
         offset     = addr - base_addr;
         page_index = longint'(offset >> PAGE_SHIFT);
         if (page_index >= managed_count()) begin
            res.status = STATUS_RANGE;
         end else begin
            mark_page(int'(page_index), 1'b0);
         end
      end
      return res;
   endfunction

   function automatic logic [FIELD_ADDR_W-1:0] random_addr();
      return {16'($urandom()), 32'($urandom())};
   endfunction

   task automatic send_request(input cmd_type op, input logic [FIELD_ADDR_W-1:0] addr);
      while (!steady_traffic && $urandom_range(99) < IDLE_PERCENT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.cmd       <= op;
      req_if.free_addr <= addr;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pending_frames.push_back(allocate_or_free(op, addr));
   endtask

   task automatic drain_requests();
      req_if.valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic program_registers(input logic [CSR_DATA_W-1:0] base,
                                    input logic [CSR_DATA_W-1:0] count,
                                    input logic [CSR_DATA_W-1:0] reserved);
      drain_requests();
      csr_wen   <= 1'b1;
      csr_index <= REG_MEM_BASE;
      csr_wdata <= base;
      @(posedge clock);
      csr_index <= REG_PAGE_COUNT;
      csr_wdata <= count;
      @(posedge clock);
      csr_index <= REG_RESERVED_PAGES;
      csr_wdata <= reserved;
      @(posedge clock);
      csr_wen        <= 1'b0;
      base_addr      = base;
      page_limit     = count[COUNT_W-1:0];
      reserved_count = reserved[COUNT_W-1:0];
   endtask

   task automatic send_mixed_traffic(input int items);
      int                      pick;
      int                      i;
      int                      used_pages [$];
      logic [FIELD_ADDR_W-1:0] addr;
      repeat (items) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            send_request(CMD_ALLOC, random_addr());
         end else if (pick < 88) begin
            used_pages = {};
            for (i = 0; i < managed_count(); i++) begin
               if (page_is_used(i)) used_pages.push_back(i);
            end
            addr = base_addr + FIELD_ADDR_W'($urandom_range(OFFSET_MAX));
            if (used_pages.size() != 0) begin
               addr += FIELD_ADDR_W'(used_pages[$urandom_range(used_pages.size() - 1)])
                       << PAGE_SHIFT;
            end
            send_request(CMD_FREE, addr);
         end else begin
            case ($urandom_range(2))
               0: addr = random_addr();
               1: addr = base_addr - 1 - FIELD_ADDR_W'($urandom_range(3 * OFFSET_MAX));
               default: addr = base_addr
                     + (FIELD_ADDR_W'(managed_count() + $urandom_range(7)) << PAGE_SHIFT)
                     + FIELD_ADDR_W'($urandom_range(OFFSET_MAX));
            endcase
            send_request(CMD_FREE, addr);
         end
      end
   endtask

   task automatic run_random_phase(input logic [CSR_DATA_W-1:0] base,
                                   input logic [CSR_DATA_W-1:0] count,
                                   input logic [CSR_DATA_W-1:0] reserved,
                                   input int items);
      program_registers(base, count, reserved);
      send_mixed_traffic(items);
   endtask

   task automatic test_reset_bootstrap();
      send_request(CMD_ALLOC, '1);
      send_request(CMD_ALLOC, '0);
      send_request(CMD_ALLOC, 48'h1234);
      send_request(CMD_FREE, 48'h1ABC);
      send_request(CMD_FREE, 48'h1000);
      send_request(CMD_ALLOC, '0);
      send_request(CMD_FREE, '1);
      send_request(CMD_FREE, 48'h3F_FFFF);
   endtask

   task automatic test_register_extremes();
      program_registers(48'hFFFF_FFFF_E000, 48'h7FF, 48'h0);
      send_request(CMD_ALLOC, '0);
      send_request(CMD_ALLOC, '0);
      send_request(CMD_ALLOC, '0);
      send_request(CMD_FREE, 48'h0);
      send_request(CMD_FREE, 48'h1000);
      program_registers(48'h40_0000, 48'h0, 48'h0);
      send_request(CMD_ALLOC, '0);
      send_request(CMD_FREE, 48'h40_0000);
      program_registers(48'h40_0000, 48'h4, 48'hA);
      send_request(CMD_ALLOC, '0);
      send_request(CMD_FREE, 48'h40_1FFF);
      send_request(CMD_ALLOC, '0);
      program_registers(48'h40_0000, 48'h1, 48'h0);
      send_request(CMD_FREE, 48'h40_0000);
      send_request(CMD_ALLOC, '0);
      send_request(CMD_ALLOC, '0);
      send_request(CMD_FREE, 48'h40_1000);
   endtask

   task automatic test_random_configs();
      logic [CSR_DATA_W-1:0] base;
      int                    count;
      run_random_phase(48'h0, 48'd1024, 48'd0, 200);
      run_random_phase(48'hFFFF_FFF0_0000, 48'd1024, 48'd1000, 160);
      repeat (8) begin
         base = random_addr();
         if ($urandom_range(3) != 0) base[PAGE_SHIFT-1:0] = '0;
         count = $urandom_range(64, 1);
         run_random_phase(base, CSR_DATA_W'(count), CSR_DATA_W'($urandom_range(count + 6)), 100);
      end
      run_random_phase(random_addr(), 48'd0, CSR_DATA_W'($urandom_range(20)), 40);
      run_random_phase(random_addr() & 48'hFFFF_FFFF_F000, random_addr() | 48'h7FF,
                       random_addr() | 48'h7FF, 150);
      run_random_phase(48'h1000, 48'd1, 48'd0, 60);
   endtask

   task automatic test_back_to_back();
      steady_traffic = 1'b1;
      run_random_phase(random_addr(), 48'd16, 48'd3, 200);
      drain_requests();
      steady_traffic = 1'b0;
   endtask

   always @(posedge clock) begin
      frame_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_frames.size() == 0) begin
            $display("%0t: unexpected response page_addr=%h status=%0d",
                     $time, rsp_if.page_addr, rsp_if.status);
            mismatches++;
         end else begin
            want = pending_frames.pop_front();
            if (rsp_if.page_addr !== want.page_addr) begin
               $display("%0t: page_addr expected %h actual %h",
                        $time, want.page_addr, rsp_if.page_addr);
               mismatches++;
            end
            if (rsp_if.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_if.status);
               mismatches++;
            end
         end
      end
      rsp_if.ready <= steady_traffic || ($urandom_range(99) >= IDLE_PERCENT);
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      reset            = 1'b1;
      csr_wen          = 1'b0;
      csr_index        = REG_MEM_BASE;
      csr_wdata        = '0;
      req_if.valid     = 1'b0;
      req_if.cmd       = CMD_ALLOC;
      req_if.free_addr = '0;
      rsp_if.ready     = 1'b0;
      base_addr        = '0;
      page_limit       = COUNT_W'(1024);
      reserved_count   = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_bootstrap();
      test_register_extremes();
      test_random_configs();
      test_back_to_back();
      drain_requests();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
